FILE: rtl/binary_image_outline_extract_unit_macros.svh
// assertion macros shared by the outline extractor modules
`ifndef BINARY_IMAGE_OUTLINE_EXTRACT_UNIT_MACROS_SVH
`define BINARY_IMAGE_OUTLINE_EXTRACT_UNIT_MACROS_SVH

// condition must hold at every edge outside reset
`define BIOE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define BIOE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BIOE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bioe_pkg.sv
// types and constants shared by the outline extractor modules
package bioe_pkg;

    localparam int SIDE_PIXELS = 64;
    localparam int ROW_BYTES   = SIDE_PIXELS / 8;
    localparam int ROW_W       = $clog2(SIDE_PIXELS);
    localparam int BCOL_W      = $clog2(ROW_BYTES);
    localparam int LINE_DEPTH  = 2 * ROW_BYTES;

    localparam int PIX_W       = 8;
    localparam int ROWIDX_W    = 6;
    localparam int BCOLIDX_W   = 3;
    localparam int IMG_W       = 8;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SIDE_PIXELS - 1);
    localparam logic [BCOL_W-1:0] LAST_BCOL = BCOL_W'(ROW_BYTES - 1);

    typedef enum logic {
        CMD_EMIT,
        CMD_EMIT_FLUSH
    } cmd_kind_t;

    // one queued request: the 3x3 neighborhood of one byte of the middle row
    typedef struct packed {
        cmd_kind_t               kind;
        logic [PIX_W-1:0]        up;
        logic [PIX_W-1:0]        mid;
        logic                    left;
        logic                    right;
        logic [PIX_W-1:0]        down;
        logic                    has_up;
        logic [ROW_W-1:0]        row;
        logic [BCOL_W-1:0]       bcol;
        logic [IMG_W-1:0]        image;
    } cmd_t;

    // last two rows of an image, kept for the bottom-row drain
    typedef struct packed {
        logic [ROW_BYTES-1:0][PIX_W-1:0] up;
        logic [ROW_BYTES-1:0][PIX_W-1:0] mid;
    } flush_rows_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: rtl/bioe_front.sv
// input side: raster position, line buffer and request classification
module bioe_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bioe_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] pixel_byte
    input  bioe_pkg::q_status_t             q_status,
    output logic                            push,
    output bioe_pkg::cmd_t                  push_cmd,
    output bioe_pkg::flush_rows_t           snap
);

    localparam int RB = bioe_pkg::ROW_BYTES;

    logic [bioe_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [bioe_pkg::BCOL_W-1:0]  bcol_reg, bcol_next;
    logic [bioe_pkg::IMG_W-1:0]   image_reg, image_next;
    logic [bioe_pkg::PIX_W-1:0]   line_reg [bioe_pkg::LINE_DEPTH];
    bioe_pkg::flush_rows_t        snap_reg;
    logic                         accept;
    logic                         row_end;
    logic                         image_end;

    assign s_tready  = !q_status.full;
    assign accept    = s_tvalid && s_tready;
    assign row_end   = (bcol_reg == bioe_pkg::LAST_BCOL);
    assign image_end = row_end && (row_reg == bioe_pkg::LAST_ROW);
    assign push      = accept && (row_reg != '0);

    // line_reg[0] is the byte one before the arriving one
    always_comb begin
        push_cmd.kind   = image_end ? bioe_pkg::CMD_EMIT_FLUSH : bioe_pkg::CMD_EMIT;
        push_cmd.up     = line_reg[2*RB-1];
        push_cmd.mid    = line_reg[RB-1];
        push_cmd.left   = line_reg[RB][0];
        push_cmd.right  = line_reg[RB-2][bioe_pkg::PIX_W-1];
        push_cmd.down   = s_tdata;
        push_cmd.has_up = (row_reg > bioe_pkg::ROW_W'(1));
        push_cmd.row    = row_reg - bioe_pkg::ROW_W'(1);
        push_cmd.bcol   = bcol_reg;
        push_cmd.image  = image_reg;
    end

    always_comb begin
        row_next   = row_reg;
        bcol_next  = bcol_reg;
        image_next = image_reg;
        if (accept) begin
            if (row_end) begin
                bcol_next = '0;
                if (image_end) begin
                    row_next   = '0;
                    image_next = image_reg + bioe_pkg::IMG_W'(1);
                end else begin
                    row_next = row_reg + bioe_pkg::ROW_W'(1);
                end
            end else begin
                bcol_next = bcol_reg + bioe_pkg::BCOL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            bcol_reg  <= '0;
            image_reg <= '0;
        end else begin
            row_reg   <= row_next;
            bcol_reg  <= bcol_next;
            image_reg <= image_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            line_reg[0] <= s_tdata;
            for (int k = 1; k < bioe_pkg::LINE_DEPTH; k++) begin
                line_reg[k] <= line_reg[k-1];
            end
        end
        // keep the final two rows for the bottom-row drain
        if (accept && image_end) begin
            for (int k = 0; k < RB - 1; k++) begin
                snap_reg.mid[k] <= line_reg[RB-2-k];
            end
            snap_reg.mid[RB-1] <= s_tdata;
            for (int k = 0; k < RB; k++) begin
                snap_reg.up[k] <= line_reg[2*RB-2-k];
            end
        end
    end

    assign snap = snap_reg;

endmodule

FILE: rtl/bioe_queue.sv
// short request queue between the front and back parts
module bioe_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  bioe_pkg::cmd_t       push_cmd,
    input  logic                 pop,
    output bioe_pkg::cmd_t       head_cmd,
    output bioe_pkg::q_status_t  q_status
);

    `include "binary_image_outline_extract_unit_macros.svh"

    bioe_pkg::cmd_t               mem_reg [bioe_pkg::QUEUE_DEPTH];
    logic [bioe_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [bioe_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [bioe_pkg::QCNT_W-1:0]  count_reg, count_next;

    assign q_status.full  = (count_reg == bioe_pkg::QCNT_W'(bioe_pkg::QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head_cmd       = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + bioe_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - bioe_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == bioe_pkg::QPTR_W'(bioe_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + bioe_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == bioe_pkg::QPTR_W'(bioe_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + bioe_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `BIOE_ASSERT_SAME(a_no_push_when_full, q_status.full, !push, "push into full queue")
    `BIOE_ASSERT_SAME(a_no_pop_when_empty, q_status.empty, !pop, "pop from empty queue")
    `BIOE_ASSERT_NEXT(a_count_tracks, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count lost a push")

endmodule

FILE: rtl/bioe_back.sv
// output side: outline marking, bottom-row drain and result register
module bioe_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bioe_pkg::cmd_t                  head_cmd,
    input  bioe_pkg::q_status_t             q_status,
    input  bioe_pkg::flush_rows_t           snap,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bioe_pkg::M_TDATA_W-1:0]  m_tdata,   // [7:0] outline_byte, [13:8] row_index,
                                                       // [16:14] byte_column, [24:17] image_number
    output logic                            m_tlast     // last_of_image
);

    `include "binary_image_outline_extract_unit_macros.svh"

    localparam int RB = bioe_pkg::ROW_BYTES;
    localparam int W  = bioe_pkg::PIX_W;

    // ext: bit W+1 is the pixel left of the byte, bit 0 the one right of it
    function automatic logic [W-1:0] mark_byte(
        input logic [W-1:0] up,
        input logic [W+1:0] ext,
        input logic [W-1:0] down,
        input logic         has_up,
        input logic         has_down,
        input logic         first_byte,
        input logic         last_byte
    );
        logic [W-1:0] res;
        logic         at_first;
        logic         at_last;
        res = '0;
        for (int i = 0; i < W; i++) begin
            at_first = first_byte && (i == 0);
            at_last  = last_byte && (i == W - 1);
            res[W-1-i] = ext[W-i] && has_up &&
                         (!up[W-1-i] ||
                          (!at_last && (!ext[W-1-i] ||
                           (has_down && (!down[W-1-i] || (!at_first && !ext[W+1-i]))))));
        end
        return res;
    endfunction

    logic                             m_tvalid_reg;
    logic                             m_tlast_reg;
    logic [W-1:0]                     out_byte_reg;
    logic [bioe_pkg::ROW_W-1:0]       out_row_reg;
    logic [bioe_pkg::BCOL_W-1:0]      out_bcol_reg;
    logic [bioe_pkg::IMG_W-1:0]       out_image_reg;

    logic                             flush_active_reg;
    logic [bioe_pkg::BCOL_W-1:0]      fb_reg;
    logic [bioe_pkg::IMG_W-1:0]       flush_image_reg;
    logic [RB-1:0][W-1:0]             up_line_reg;
    logic [RB-1:0][W-1:0]             mid_line_reg;
    logic                             prev_bit_reg;

    logic                             out_load;
    logic [W-1:0]                     emit_byte;
    logic [W-1:0]                     flush_byte;
    logic                             fb_last;

    assign out_load = !m_tvalid_reg || m_tready;
    assign pop      = out_load && !flush_active_reg && !q_status.empty;
    assign fb_last  = (fb_reg == bioe_pkg::LAST_BCOL);

    assign emit_byte = mark_byte(head_cmd.up, {head_cmd.left, head_cmd.mid, head_cmd.right},
                                 head_cmd.down, head_cmd.has_up, 1'b1,
                                 head_cmd.bcol == '0,
                                 head_cmd.bcol == bioe_pkg::LAST_BCOL);

    // bottom row: no down neighbor, the row walks past a fixed tap
    assign flush_byte = mark_byte(up_line_reg[0],
                                  {prev_bit_reg, mid_line_reg[0], mid_line_reg[1][W-1]},
                                  '0, 1'b1, 1'b0, fb_reg == '0, fb_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg     <= 1'b0;
            flush_active_reg <= 1'b0;
            fb_reg           <= '0;
        end else if (out_load) begin
            if (flush_active_reg) begin
                m_tvalid_reg <= 1'b1;
                fb_reg       <= fb_reg + bioe_pkg::BCOL_W'(1);
                if (fb_last) begin
                    flush_active_reg <= 1'b0;
                end
            end else if (!q_status.empty) begin
                m_tvalid_reg <= 1'b1;
                if (head_cmd.kind == bioe_pkg::CMD_EMIT_FLUSH) begin
                    flush_active_reg <= 1'b1;
                    fb_reg           <= '0;
                end
            end else begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (flush_active_reg) begin
                out_byte_reg  <= flush_byte;
                out_row_reg   <= bioe_pkg::LAST_ROW;
                out_bcol_reg  <= fb_reg;
                out_image_reg <= flush_image_reg;
                m_tlast_reg   <= fb_last;
                prev_bit_reg  <= mid_line_reg[0][0];
                for (int k = 0; k < RB - 1; k++) begin
                    up_line_reg[k]  <= up_line_reg[k+1];
                    mid_line_reg[k] <= mid_line_reg[k+1];
                end
            end else if (!q_status.empty) begin
                out_byte_reg  <= emit_byte;
                out_row_reg   <= head_cmd.row;
                out_bcol_reg  <= head_cmd.bcol;
                out_image_reg <= head_cmd.image;
                m_tlast_reg   <= 1'b0;
                if (head_cmd.kind == bioe_pkg::CMD_EMIT_FLUSH) begin
                    up_line_reg     <= snap.up;
                    mid_line_reg    <= snap.mid;
                    prev_bit_reg    <= 1'b0;
                    flush_image_reg <= head_cmd.image;
                end
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {{(bioe_pkg::M_TDATA_W - W - bioe_pkg::ROWIDX_W - bioe_pkg::BCOLIDX_W
                         - bioe_pkg::IMG_W){1'b0}},
                       out_image_reg,
                       bioe_pkg::BCOLIDX_W'(out_bcol_reg),
                       bioe_pkg::ROWIDX_W'(out_row_reg),
                       out_byte_reg};

    `BIOE_ASSERT_SAME(a_last_on_final_byte, m_tvalid && m_tlast, (out_row_reg == bioe_pkg::LAST_ROW) && (out_bcol_reg == bioe_pkg::LAST_BCOL), "tlast away from the final byte")
    `BIOE_ASSERT_SAME(a_drain_full_row, $fell(flush_active_reg), $past(fb_reg) == bioe_pkg::LAST_BCOL, "bottom-row drain ended early")

endmodule

FILE: rtl/binary_image_outline_extract_unit.sv
// top level of the binary image outline extractor
//
//   channel   dir   width  contents
//   s_        in    8      pixel_byte, raster order, one byte per request
//   m_        out   32+1   outline_byte, row_index, byte_column, image_number; tlast
//
// one input byte per cycle while s_tready is high; results leave one per cycle while
// m_tready is high, after the input byte that causes them (request queue, then the
// output register). the last byte of an image starts a drain in the back part: the
// pending byte of the next-to-last row, then the eight bytes of the bottom row,
// running while the first row of the next image arrives, which makes no results.
// reset clears counters, queue pointers and valid flags; line buffers are not cleared.
// s_tready drops only when the four-entry request queue is full.
module binary_image_outline_extract_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bioe_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] pixel_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bioe_pkg::M_TDATA_W-1:0]  m_tdata,   // [7:0] outline_byte, [13:8] row_index,
                                                       // [16:14] byte_column, [24:17] image_number
    output logic                            m_tlast     // last_of_image
);

    bioe_pkg::q_status_t    q_status;
    bioe_pkg::cmd_t         push_cmd;
    bioe_pkg::cmd_t         head_cmd;
    bioe_pkg::flush_rows_t  snap;
    logic                   push;
    logic                   pop;

    bioe_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd),
        .snap     (snap)
    );

    bioe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_status (q_status)
    );

    bioe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .q_status (q_status),
        .snap     (snap),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
